### rtl/wdps_pkg.sv
// shared types, constants and codes for the waveform deframer with pedestal subtraction
`timescale 1ns / 1ps

package wdps_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int HEADER_LEN   = 8;
    localparam int HDR_BYTES    = HEADER_LEN * 4;

    localparam int HDR_SIZE    = 0;
    localparam int HDR_BOARD   = 1;
    localparam int HDR_CHANNEL = 3;
    localparam int HDR_EVENT   = 4;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 30;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W   = 32;
    localparam int TDATA_W = 224;

    localparam logic [6:0] WINDOW_RESET = 7'd16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b1;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_ALIGN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVGO,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic ped_load;
        logic rd_en;
        logic burst_emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic emit_now;
        logic need_div;
        logic div_done;
        logic burst_last;
    } sts_t;

endpackage

### rtl/wdps_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module wdps_div #(
    parameter int DIV_W = 39,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/wdps_datapath.sv
// header parsing, window buffer, pedestal divider and result register
`timescale 1ns / 1ps

module wdps_datapath #(
    parameter int MAX_WINDOW = wdps_pkg::MAX_WINDOW
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [wdps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wdps_pkg::CFG_W-1:0]         cfg_data,
    input  logic [wdps_pkg::WORD_W-1:0]        s_tdata,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [wdps_pkg::TDATA_W-1:0]       m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    input  wdps_pkg::cmd_t                     cmd,
    output wdps_pkg::sts_t                     sts
);

    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = 33 + $clog2(MAX_WINDOW);
    localparam int CW     = wdps_pkg::COUNT_W;

    // configuration
    logic [6:0]  window_reg;
    logic [31:0] target_reg;

    // framing and event state
    logic              in_payload_reg;
    logic [CW-1:0]     pos_reg;
    logic [31:0]       size_reg;
    logic [31:0]       board_reg;
    logic [31:0]       chan_reg;
    logic [31:0]       evt_reg;
    logic [CW-1:0]     count_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [31:0]       ped_reg;
    logic              ped_ready_reg;
    logic [WIN_W-1:0]  k_reg;
    logic              neg_reg;

    logic [31:0] mem [MAX_WINDOW];
    logic [31:0] rdata_reg;

    // result register
    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [31:0]   out_board_reg;
    logic [31:0]   out_chan_reg;
    logic [31:0]   out_evt_reg;
    logic [CW-1:0] out_count_reg;
    logic [CW-1:0] out_idx_reg;
    logic [31:0]   out_corr_reg;
    logic [31:0]   out_ped_reg;
    logic [1:0]    out_err_reg;
    logic          out_last_reg;

    logic             hdr_last;
    logic             err_short;
    logic             err_align;
    logic [31:0]      size_minus;
    logic [CW-1:0]    cnt_new;
    logic [31:0]      w_a;
    logic [31:0]      w_b;
    logic [31:0]      w_c;
    logic [WIN_W-1:0] win_new;
    logic             win_done;
    logic             pay_end;
    logic [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0] dividend;
    logic             div_done;
    logic [SUM_W-1:0] quotient;
    logic             out_free;
    logic             load_hdr;
    logic             load_smp;
    logic             load_burst;
    logic [31:0]      corr_in;
    logic [CW-1:0]    idx_in;

    function automatic logic [31:0] sat_corr(input logic [31:0] s,
                                             input logic [31:0] ped,
                                             input logic [31:0] tgt);
        logic [33:0] v;
        v = {{2{s[31]}}, s} - {{2{ped[31]}}, ped} + {{2{tgt[31]}}, tgt};
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            sat_corr = v[31:0];
        end
        else
        begin
            sat_corr = v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    endfunction

    // header checks, window clamp, window and payload end tests and divider operand
    always_comb
    begin
        hdr_last   = !in_payload_reg && (pos_reg == CW'(wdps_pkg::HEADER_LEN - 1));
        err_short  = size_reg <= 32'(wdps_pkg::HDR_BYTES);
        err_align  = size_reg[1:0] != 2'b00;
        size_minus = size_reg - 32'(wdps_pkg::HDR_BYTES);
        cnt_new    = size_minus[31:2];
        w_a        = (window_reg == 7'd0) ? 32'd1 : {25'd0, window_reg};
        w_b        = (w_a > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : w_a;
        w_c        = (w_b > {2'b00, cnt_new}) ? {2'b00, cnt_new} : w_b;
        win_new    = w_c[WIN_W-1:0];
        win_done   = ({1'b0, pos_reg} + 1'b1) >= (CW + 1)'(win_reg);
        pay_end    = ({1'b0, pos_reg} + 1'b1) >= {1'b0, count_reg};
        sum_add    = sum_reg + {{(SUM_W - 32){s_tdata[31]}}, s_tdata};
        dividend   = sum_reg[SUM_W-1]
                   ? (SUM_W'(0) - sum_reg) + SUM_W'(win_reg) - SUM_W'(1)
                   : sum_reg;
    end

    wdps_div #(
        .DIV_W (SUM_W),
        .DEN_W (WIN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= wdps_pkg::WINDOW_RESET;
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wdps_pkg::REG_WINDOW: window_reg <= cfg_data[6:0];
                wdps_pkg::REG_TARGET: target_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_payload_reg <= 1'b0;
            pos_reg        <= '0;
            size_reg       <= '0;
            board_reg      <= '0;
            chan_reg       <= '0;
            evt_reg        <= '0;
            count_reg      <= '0;
            win_reg        <= '0;
            sum_reg        <= '0;
            ped_reg        <= '0;
            ped_ready_reg  <= 1'b0;
            k_reg          <= '0;
            neg_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (!in_payload_reg)
                begin
                    if (pos_reg == CW'(wdps_pkg::HDR_SIZE))
                    begin
                        size_reg <= s_tdata;
                    end
                    if (pos_reg == CW'(wdps_pkg::HDR_BOARD))
                    begin
                        board_reg <= s_tdata;
                    end
                    if (pos_reg == CW'(wdps_pkg::HDR_CHANNEL))
                    begin
                        chan_reg <= s_tdata;
                    end
                    if (pos_reg == CW'(wdps_pkg::HDR_EVENT))
                    begin
                        evt_reg <= s_tdata;
                    end
                    if (hdr_last)
                    begin
                        pos_reg <= '0;
                        if (!err_short && !err_align)
                        begin
                            count_reg      <= cnt_new;
                            win_reg        <= win_new;
                            sum_reg        <= '0;
                            ped_reg        <= '0;
                            ped_ready_reg  <= 1'b0;
                            in_payload_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!ped_ready_reg)
                    begin
                        sum_reg <= sum_add;
                    end
                    if (pay_end)
                    begin
                        pos_reg        <= '0;
                        in_payload_reg <= 1'b0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
            end
            if (cmd.div_start)
            begin
                neg_reg <= sum_reg[SUM_W-1];
            end
            if (cmd.ped_load)
            begin
                ped_reg       <= neg_reg ? (32'd0 - quotient[31:0]) : quotient[31:0];
                ped_ready_reg <= 1'b1;
                k_reg         <= '0;
            end
            if (cmd.burst_emit)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // window sample buffer
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_payload_reg && !ped_ready_reg)
        begin
            mem[pos_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[k_reg[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        out_free   = !out_valid_reg || m_tready;
        load_hdr   = cmd.take && hdr_last;
        load_smp   = cmd.take && in_payload_reg && ped_ready_reg;
        load_burst = cmd.burst_emit;
        corr_in    = sat_corr(load_burst ? rdata_reg : s_tdata, ped_reg, target_reg);
        idx_in     = load_burst ? CW'(k_reg) : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_hdr || load_smp || load_burst)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hdr)
        begin
            out_board_reg <= board_reg;
            out_chan_reg  <= chan_reg;
            out_evt_reg   <= evt_reg;
            out_idx_reg   <= '0;
            out_corr_reg  <= '0;
            out_ped_reg   <= '0;
            out_last_reg  <= 1'b1;
            if (err_short)
            begin
                out_kind_reg  <= wdps_pkg::KIND_ERROR;
                out_count_reg <= '0;
                out_err_reg   <= wdps_pkg::ERR_SHORT;
            end
            else if (err_align)
            begin
                out_kind_reg  <= wdps_pkg::KIND_ERROR;
                out_count_reg <= '0;
                out_err_reg   <= wdps_pkg::ERR_ALIGN;
            end
            else
            begin
                out_kind_reg  <= wdps_pkg::KIND_HEADER;
                out_count_reg <= cnt_new;
                out_err_reg   <= wdps_pkg::ERR_NONE;
            end
        end
        else if (load_smp || load_burst)
        begin
            out_kind_reg  <= wdps_pkg::KIND_SAMPLE;
            out_board_reg <= board_reg;
            out_chan_reg  <= chan_reg;
            out_evt_reg   <= evt_reg;
            out_count_reg <= count_reg;
            out_idx_reg   <= idx_in;
            out_corr_reg  <= corr_in;
            out_ped_reg   <= ped_reg;
            out_err_reg   <= wdps_pkg::ERR_NONE;
            out_last_reg  <= load_burst
                           ? (({1'b0, k_reg} + 1'b1) == {1'b0, win_reg})
                           : 1'b1;
        end
    end

    always_comb
    begin
        sts.out_free   = out_free;
        sts.emit_now   = hdr_last || (in_payload_reg && ped_ready_reg);
        sts.need_div   = in_payload_reg && !ped_ready_reg && win_done;
        sts.div_done   = div_done;
        sts.burst_last = ({1'b0, k_reg} + 1'b1) == {1'b0, win_reg};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_err_reg, out_ped_reg, out_corr_reg, out_idx_reg,
                       out_count_reg, out_evt_reg, out_chan_reg, out_board_reg};

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (load_hdr || load_smp || load_burst) |-> out_free)
        else $error("result register overwritten while occupied");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == wdps_pkg::KIND_ERROR) |-> (out_err_reg != wdps_pkg::ERR_NONE))
        else $error("framing error result without error code");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.burst_emit |-> (ped_ready_reg && k_reg < win_reg))
        else $error("window replay outside of window");

    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (!ped_ready_reg && win_reg != '0))
        else $error("pedestal division started without a pending window");

endmodule

### rtl/wdps_ctrl.sv
// controller state machine for request intake, pedestal division and window replay
`timescale 1ns / 1ps

module wdps_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  wdps_pkg::sts_t  sts,
    output wdps_pkg::cmd_t  cmd
);

    wdps_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wdps_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            wdps_pkg::ST_IDLE:
            begin
                s_tready = sts.out_free || !sts.emit_now;
                if (s_tvalid && s_tready)
                begin
                    cmd.take = 1'b1;
                    if (sts.need_div)
                    begin
                        state_next = wdps_pkg::ST_DIVGO;
                    end
                end
            end
            wdps_pkg::ST_DIVGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = wdps_pkg::ST_DIV;
            end
            wdps_pkg::ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.ped_load = 1'b1;
                    state_next   = wdps_pkg::ST_READ;
                end
            end
            wdps_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = wdps_pkg::ST_EMIT;
            end
            wdps_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.burst_emit = 1'b1;
                    state_next     = sts.burst_last ? wdps_pkg::ST_IDLE : wdps_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = wdps_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/waveform_deframe_pedestal_subtract.sv
// top level of the digitizer event deframer with pedestal subtraction
`timescale 1ns / 1ps

// One 32-bit stream word is taken per cycle while the block is in its intake
// state, unless the word makes a result while the output register is still
// occupied. When the last window sample of an event arrives, intake pauses for
// the pedestal: the divider is launched and produces one quotient bit per
// cycle, the pedestal is loaded, then each window sample is read back from the
// window buffer and corrected, waiting while the output register is occupied.
// Results leave through a single output register; a word that makes no
// result is taken even while a result waits there. tdata carries, from bit 0:
// board_id, channel_id, event_counter, sample_count, sample_index,
// corrected_sample, pedestal_value, error_code and two zero bits; tuser holds
// result_kind and tlast marks the final result caused by one input word.
module waveform_deframe_pedestal_subtract #(
    parameter int MAX_WINDOW = wdps_pkg::MAX_WINDOW
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wdps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wdps_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [wdps_pkg::WORD_W-1:0]      s_tdata,   // stream_word
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // board_id, channel_id, event_counter, sample_count, sample_index,
    // corrected_sample, pedestal_value, error_code, zero padding
    output logic [wdps_pkg::TDATA_W-1:0]     m_tdata,
    output logic [1:0]                       m_tuser,   // result_kind
    output logic                             m_tlast
);

    wdps_pkg::cmd_t cmd;
    wdps_pkg::sts_t sts;

    wdps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wdps_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### verif/waveform_deframe_pedestal_subtract_test.sv
// self-checking testbench for the event deframer with pedestal subtraction
`timescale 1ns / 1ps

module waveform_deframe_pedestal_subtract_test;

    localparam int SETTLE_CYCLES  = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 12;

    localparam longint SAT_HIGH = 64'sd2147483647;
    localparam longint SAT_LOW  = -64'sd2147483648;

    typedef enum int {
        SAMP_RANDOM,
        SAMP_BASELINE,
        SAMP_EXTREME
    } sample_mode_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_PERIODIC,
        READY_MOSTLY
    } ready_mode_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] board_id;
        logic [31:0] channel_id;
        logic [31:0] event_counter;
        logic [29:0] sample_count;
        logic [29:0] sample_index;
        logic [31:0] corrected;
        logic [31:0] pedestal;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [wdps_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wdps_pkg::CFG_W-1:0]     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [wdps_pkg::WORD_W-1:0]    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [wdps_pkg::TDATA_W-1:0]   m_tdata;
    logic [1:0]                     m_tuser;
    logic                           m_tlast;

    // predictor copy of configuration and framing state
    logic [6:0]  cfg_window = wdps_pkg::WINDOW_RESET;
    logic [31:0] cfg_target = '0;
    bit          frame_in_payload;
    int unsigned frame_pos;
    logic [31:0] frame_size;
    logic [31:0] frame_board;
    logic [31:0] frame_channel;
    logic [31:0] frame_event;
    int unsigned frame_count;
    int unsigned frame_window;
    longint      window_sum;
    int          window_store [wdps_pkg::MAX_WINDOW];
    longint      frame_pedestal;
    bit          pedestal_known;

    result_t awaited_results [$];
    result_t want_result;

    int  mismatches;
    int  results_seen;
    int  words_sent;
    int  settings_written;
    int  burst_left;
    bit  sender_steady;
    bit  hold_off_request;

    waveform_deframe_pedestal_subtract u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] sat32(longint x);
        if (x > SAT_HIGH)
            return 32'h7FFF_FFFF;
        if (x < SAT_LOW)
            return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic result_t make_result(logic [1:0] kind, int unsigned count,
                                            int unsigned index, longint corr,
                                            longint ped, logic [1:0] err);
        result_t r;
        r.kind          = kind;
        r.board_id      = frame_board;
        r.channel_id    = frame_channel;
        r.event_counter = frame_event;
        r.sample_count  = count[29:0];
        r.sample_index  = index[29:0];
        r.corrected     = sat32(corr);
        r.pedestal      = sat32(ped);
        r.error_code    = err;
        r.last          = 1'b0;
        return r;
    endfunction

    function automatic longint correct_sample(longint s);
        return s - frame_pedestal + longint'($signed(cfg_target));
    endfunction

    function automatic void deframe_and_correct(input logic [31:0] w);
        result_t     batch [$];
        int unsigned pos;
        longint      s;
        longint      q;
        longint      rem;
        if (!frame_in_payload)
        begin
            pos = frame_pos;
            case (pos)
                wdps_pkg::HDR_SIZE:    frame_size    = w;
                wdps_pkg::HDR_BOARD:   frame_board   = w;
                wdps_pkg::HDR_CHANNEL: frame_channel = w;
                wdps_pkg::HDR_EVENT:   frame_event   = w;
                default: ;
            endcase
            if (pos >= wdps_pkg::HEADER_LEN - 1)
            begin
                frame_pos = 0;
                if (frame_size <= 32'(wdps_pkg::HDR_BYTES))
                    batch.insert(batch.size(), make_result(wdps_pkg::KIND_ERROR, 0, 0, 0, 0,
                                                           wdps_pkg::ERR_SHORT));
                else if (((frame_size - 32'(wdps_pkg::HDR_BYTES)) & 32'd3) != 0)
                    batch.insert(batch.size(), make_result(wdps_pkg::KIND_ERROR, 0, 0, 0, 0,
                                                           wdps_pkg::ERR_ALIGN));
                else
                begin
                    frame_count  = (frame_size - 32'(wdps_pkg::HDR_BYTES)) >> 2;
                    frame_window = cfg_window;
                    if (frame_window < 1)
                        frame_window = 1;
                    if (frame_window > wdps_pkg::MAX_WINDOW)
                        frame_window = wdps_pkg::MAX_WINDOW;
                    if (frame_window > frame_count)
                        frame_window = frame_count;
                    window_sum       = 0;
                    frame_pedestal   = 0;
                    pedestal_known   = 1'b0;
                    frame_in_payload = 1'b1;
                    batch.insert(batch.size(), make_result(wdps_pkg::KIND_HEADER, frame_count,
                                                           0, 0, 0, wdps_pkg::ERR_NONE));
                end
            end
            else
                frame_pos = pos + 1;
        end
        else
        begin
            pos = frame_pos;
            s   = longint'($signed(w));
            if (!pedestal_known)
            begin
                if (pos < wdps_pkg::MAX_WINDOW)
                    window_store[pos] = $signed(w);
                window_sum += s;
                if (pos + 1 >= frame_window)
                begin
                    // floor mean of the window
                    q   = window_sum / longint'(frame_window);
                    rem = window_sum % longint'(frame_window);
                    if (rem < 0)
                        q -= 1;
                    frame_pedestal = q;
                    pedestal_known = 1'b1;
                    for (int k = 0; k < frame_window && k < wdps_pkg::MAX_WINDOW; k++)
                        batch.insert(batch.size(), make_result(wdps_pkg::KIND_SAMPLE,
                            frame_count, k, correct_sample(longint'(window_store[k])),
                            frame_pedestal, wdps_pkg::ERR_NONE));
                end
            end
            else
                batch.insert(batch.size(), make_result(wdps_pkg::KIND_SAMPLE, frame_count, pos,
                             correct_sample(s), frame_pedestal, wdps_pkg::ERR_NONE));
            if (pos + 1 >= frame_count)
            begin
                frame_in_payload = 1'b0;
                frame_pos        = 0;
            end
            else
                frame_pos = pos + 1;
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            awaited_results.insert(awaited_results.size(), batch[k]);
    endfunction

    function automatic logic [31:0] sample_word(sample_mode_t mode, logic [31:0] base);
        case (mode)
            SAMP_RANDOM:   return $urandom;
            SAMP_BASELINE: return base + $urandom_range(0, 255) - 32'd128;
            default:
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $display("%0t mismatch unexpected result expected none actual kind %0d data %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end
            else
            begin
                want_result = awaited_results.pop_front();
                check_field("result_kind", want_result.kind, m_tuser);
                check_field("board_id", want_result.board_id, m_tdata[31:0]);
                check_field("channel_id", want_result.channel_id, m_tdata[63:32]);
                check_field("event_counter", want_result.event_counter, m_tdata[95:64]);
                check_field("sample_count", want_result.sample_count, m_tdata[125:96]);
                check_field("sample_index", want_result.sample_index, m_tdata[155:126]);
                check_field("corrected_sample", want_result.corrected, m_tdata[187:156]);
                check_field("pedestal_value", want_result.pedestal, m_tdata[219:188]);
                check_field("error_code", want_result.error_code, m_tdata[221:220]);
                check_field("last_of_run", want_result.last, m_tlast);
            end
        end
    end

    initial
    begin : receiver
        int          phase_left;
        int          k;
        ready_mode_t ready_mode;
        phase_left = 0;
        ready_mode = READY_ALWAYS;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                hold_off_request = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    ready_mode = ready_mode_t'($urandom_range(0, 3));
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                case (ready_mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
                    READY_PERIODIC: m_tready <= ((phase_left % 3) != 0);
                    default:        m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(input logic [31:0] w);
        int gap;
        if (!sender_steady)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        deframe_and_correct(w);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic set_config(input logic [31:0] window_word, input logic [31:0] target_word);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= wdps_pkg::REG_WINDOW;
        cfg_data  <= window_word;
        @(posedge clk);
        cfg_window = window_word[6:0];
        cfg_index <= wdps_pkg::REG_TARGET;
        cfg_data  <= target_word;
        @(posedge clk);
        cfg_target = target_word;
        cfg_we <= 1'b0;
        settings_written++;
    endtask

    task automatic send_header(input logic [31:0] size);
        for (int h = 0; h < wdps_pkg::HEADER_LEN; h++)
            send_word((h == wdps_pkg::HDR_SIZE) ? size : 32'($urandom));
    endtask

    task automatic send_samples(input int n, input sample_mode_t mode);
        logic [31:0] base;
        base = $urandom;
        for (int k = 0; k < n; k++)
            send_word(sample_word(mode, base));
    endtask

    task automatic send_event(input logic [31:0] size, input int n, input sample_mode_t mode);
        send_header(size);
        send_samples(n, mode);
    endtask

    task automatic send_good_event(input int n, input sample_mode_t mode);
        send_event(32'(wdps_pkg::HDR_BYTES + 4 * n), n, mode);
    endtask

    task automatic test_framing_errors();
        send_event(32'(wdps_pkg::HDR_BYTES), 0, SAMP_RANDOM);
        send_event(32'(wdps_pkg::HDR_BYTES + 3), 0, SAMP_RANDOM);
    endtask

    task automatic test_short_events();
        send_good_event(3, SAMP_EXTREME);
    endtask

    task automatic test_window_clamp();
        // zero window with junk above the register width
        set_config($urandom & 32'hFFFF_FF80, 32'h8000_0000);
        send_good_event(2, SAMP_EXTREME);
        set_config(32'd127, 32'h7FFF_FFFF);
        send_good_event(2, SAMP_EXTREME);
    endtask

    task automatic test_window_latch();
        set_config(32'd2, 32'd0);
        send_header(32'(wdps_pkg::HDR_BYTES + 4 * 4));
        send_samples(3, SAMP_BASELINE);
        // new window only applies from the next header
        set_config(32'd5, 32'd100);
        send_samples(1, SAMP_BASELINE);
        send_good_event(3, SAMP_BASELINE);
    endtask

    task automatic test_full_stall();
        set_config(32'd2, $urandom);
        sender_steady    = 1'b1;
        hold_off_request = 1'b1;
        send_good_event(4, SAMP_BASELINE);
        wait_drain();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_stream();
        int          start;
        int          roll;
        logic [31:0] size;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            roll          = $urandom_range(0, 9);
            sender_steady = ($urandom_range(0, 3) == 0);
            if (roll == 0)
                set_config(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 12),
                           ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 512));
            else if (roll <= 2)
            begin
                // broken header, either too short or misaligned
                if ($urandom_range(0, 1) == 0)
                    size = $urandom_range(0, wdps_pkg::HDR_BYTES);
                else
                    size = {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'($urandom_range(1, 3))};
                send_event(size, 0, SAMP_RANDOM);
            end
            else
                send_good_event($urandom_range(1, 6), sample_mode_t'($urandom_range(0, 2)));
        end
        sender_steady = 1'b0;
    endtask

    task automatic test_largest_event();
        set_config(32'd3, $urandom);
        send_event(32'hFFFF_FFFC, 4, SAMP_RANDOM);
    endtask

    initial
    begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= wdps_pkg::REG_WINDOW;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_framing_errors();
        test_short_events();
        test_window_clamp();
        test_window_latch();
        test_full_stall();
        test_random_stream();
        test_largest_event();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d stream words, %0d results and %0d register settings",
                 words_sent, results_seen, settings_written);
        $display("framing errors, short events, window clamps, saturation, a mid-event write "
                 , "and a full output stall were included");
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
rtl/wdps_pkg.sv
rtl/wdps_div.sv
rtl/wdps_datapath.sv
rtl/wdps_ctrl.sv
rtl/waveform_deframe_pedestal_subtract.sv
verif/waveform_deframe_pedestal_subtract_test.sv
